// ----- design/gdda_pkg.sv -----
// ---------------------------------------------------------------------------
// gdda_pkg
// types, constants and helpers shared by the grid ray caster
// ---------------------------------------------------------------------------
package gdda_pkg;

   localparam int MAP_W     = 64;
   localparam int MAP_H     = 64;
   localparam int MAP_N     = MAP_W * MAP_H;
   localparam int MAP_AW    = $clog2(MAP_N);
   localparam int MAP_MAXD  = (MAP_W > MAP_H) ? MAP_W : MAP_H;
   localparam int CW        = ($clog2(MAP_MAXD) + 2 > 8) ? $clog2(MAP_MAXD) + 2 : 8;
   localparam int LW        = CW + 17;
   localparam int GW        = 12;
   localparam int GUARD_MAX = MAP_W + MAP_H + 2;
   localparam int RW        = 34;

   localparam logic [63:0] DD_INF   = 64'h4000_0000_0000_0000;
   localparam logic [63:0] TWO_32   = 64'h0000_0001_0000_0000;
   localparam logic [23:0] DIST_MAX = 24'hFF_FFFF;
   localparam logic [16:0] ONE_Q16  = 17'h1_0000;

   localparam logic [2:0] REG_PLAYER_X = 3'd0;
   localparam logic [2:0] REG_PLAYER_Y = 3'd1;
   localparam logic [2:0] REG_DIR_X    = 3'd2;
   localparam logic [2:0] REG_DIR_Y    = 3'd3;
   localparam logic [2:0] REG_PLANE_X  = 3'd4;
   localparam logic [2:0] REG_PLANE_Y  = 3'd5;
   localparam logic [2:0] REG_SCREEN_W = 3'd6;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CAST  = 1'b1;

   localparam logic [1:0] FACE_XF = 2'd0;
   localparam logic [1:0] FACE_YF = 2'd1;
   localparam logic [1:0] FACE_XB = 2'd2;
   localparam logic [1:0] FACE_YB = 2'd3;

   typedef logic signed [CW-1:0] coord_type;

   typedef enum logic [3:0] {
      ST_CLR, ST_IDLE, ST_CAM, ST_MX, ST_MY, ST_CK0, ST_DX, ST_DY,
      ST_SX, ST_SY, ST_STEP, ST_WCK, ST_DIST, ST_FIN
   } state_type;

   typedef enum logic {
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic        command;
      logic [5:0]  cell_x;
      logic [5:0]  cell_y;
      logic        cell_is_wall;
      logic [11:0] column;
   } req_type;

   typedef struct packed {
      logic [1:0]  hit_face;
      logic [23:0] wall_distance;
      logic [5:0]  hit_x;
      logic [5:0]  hit_y;
      logic        escaped;
   } rsp_type;

   typedef struct packed {
      logic        start;
      alu_op_type  op;
      logic [63:0] a;
      logic [63:0] b;
   } alu_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } alu_rsp_type;

   function automatic logic coord_out(coord_type c, int lim);
      return (c < 0) || (c >= coord_type'(lim));
   endfunction

   function automatic logic [MAP_AW-1:0] map_addr(coord_type cx, coord_type cy);
      return MAP_AW'(MAP_AW'(cy) * MAP_AW'(MAP_W) + MAP_AW'(cx));
   endfunction

endpackage

// ----- design/gdda_alu.sv -----
// ---------------------------------------------------------------------------
// gdda_alu
// shared 64-bit shift-add multiplier and restoring divider, one bit a cycle
// ---------------------------------------------------------------------------
module gdda_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  gdda_pkg::alu_req_type alu_req,
   output gdda_pkg::alu_rsp_type alu_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   gdda_pkg::alu_op_type op_ff, op_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [63:0]          acc_ff, acc_in;
   logic [63:0]          opa_ff, opa_in;
   logic [63:0]          opb_ff, opb_in;
   logic [64:0]          rem;
   logic [64:0]          diff;
   logic                 ge;

   assign rem  = {acc_ff, opa_ff[63]};
   assign diff = rem - {1'b0, opb_ff};
   assign ge   = rem >= {1'b0, opb_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      if (!busy_ff) begin
         if (alu_req.start) begin
            busy_in = 1'b1;
            op_in   = alu_req.op;
            cnt_in  = 6'd63;
            acc_in  = '0;
            opa_in  = alu_req.a;
            opb_in  = alu_req.b;
         end
      end else begin
         case (op_ff)
            gdda_pkg::ALU_MUL: begin
               acc_in = acc_ff + (opb_ff[0] ? opa_ff : 64'd0);
               opa_in = {opa_ff[62:0], 1'b0};
               opb_in = {1'b0, opb_ff[63:1]};
            end
            gdda_pkg::ALU_DIV: begin
               acc_in = ge ? diff[63:0] : rem[63:0];
               opa_in = {opa_ff[62:0], ge};
            end
            default: ;
         endcase
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
   end

   assign alu_rsp.done   = done_ff;
   assign alu_rsp.result = (op_ff == gdda_pkg::ALU_MUL) ? acc_ff : opa_ff;

endmodule

// ----- design/grid_ray_cast_dda_top.sv -----
// ---------------------------------------------------------------------------
// grid_ray_cast_dda_top
// grid ray caster: wall bit map, per-column ray setup and cell-by-cell walk
// ---------------------------------------------------------------------------
// a cell write is done in the idle state; a cast runs seven setup operations
// in the shared multiply/divide unit, walks cell by cell through the step and
// wall check states, runs the final distance divide and hands over the result
// one item at a time, paced by the shared one bit per cycle unit and rsp_ready
// after reset all 4096 map cells are cleared one a cycle, no item taken
// ---------------------------------------------------------------------------
module grid_ray_cast_dda_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gdda_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gdda_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   gdda_pkg::state_type state_ff, state_in;

   logic [21:0]        player_x_ff, player_y_ff;
   logic signed [17:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;
   logic [12:0]        screen_w_ff;

   logic [gdda_pkg::MAP_AW-1:0] clr_ff, clr_in;
   logic signed [31:0]          cam_ff, cam_in;
   logic signed [gdda_pkg::RW-1:0] rdx_ff, rdx_in, rdy_ff, rdy_in;
   gdda_pkg::coord_type         mx_ff, mx_in, my_ff, my_in;
   logic [63:0]                 ddx_ff, ddx_in, ddy_ff, ddy_in;
   logic [63:0]                 sdx_ff, sdx_in, sdy_ff, sdy_in;
   logic [1:0]                  face_ff, face_in;
   logic [gdda_pkg::GW-1:0]     guard_ff, guard_in;
   gdda_pkg::rsp_type           pend_ff, pend_in;
   gdda_pkg::rsp_type           rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        map_mem [gdda_pkg::MAP_N];
   logic                        rd_ff;
   logic                        wr_en, wr_bit;
   logic [gdda_pkg::MAP_AW-1:0] wr_addr;

   gdda_pkg::alu_req_type alu_req;
   gdda_pkg::alu_rsp_type alu_rsp;

   logic                        csr_wr;
   logic [2:0]                  csr_idx;
   logic [12:0]                 w_eff;
   logic [gdda_pkg::RW-2:0]     ax, ay;
   logic [31:0]                 cam_mag;
   logic signed [63:0]          prod_s;
   logic signed [63:0]          prod_sh;
   logic                        prod_neg;
   logic [16:0]                 partx, party;
   logic                        take_x;
   gdda_pkg::coord_type         nx, ny;
   gdda_pkg::coord_type         line_c;
   logic signed [gdda_pkg::LW-1:0] line_q, line_d;
   logic [gdda_pkg::LW-1:0]     line_m;
   logic [63:0]                 dist_den;
   gdda_pkg::rsp_type           esc_rsp;

   gdda_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[4:2];

   always_comb begin
      case (csr_idx)
         gdda_pkg::REG_PLAYER_X: prdata = {10'd0, player_x_ff};
         gdda_pkg::REG_PLAYER_Y: prdata = {10'd0, player_y_ff};
         gdda_pkg::REG_DIR_X:    prdata = {14'd0, dir_x_ff};
         gdda_pkg::REG_DIR_Y:    prdata = {14'd0, dir_y_ff};
         gdda_pkg::REG_PLANE_X:  prdata = {14'd0, plane_x_ff};
         gdda_pkg::REG_PLANE_Y:  prdata = {14'd0, plane_y_ff};
         gdda_pkg::REG_SCREEN_W: prdata = {19'd0, screen_w_ff};
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         player_x_ff <= '0;
         player_y_ff <= '0;
         dir_x_ff    <= 18'sd65536;
         dir_y_ff    <= '0;
         plane_x_ff  <= '0;
         plane_y_ff  <= 18'sd43254;
         screen_w_ff <= 13'd640;
      end else if (csr_wr) begin
         case (csr_idx)
            gdda_pkg::REG_PLAYER_X: player_x_ff <= pwdata[21:0];
            gdda_pkg::REG_PLAYER_Y: player_y_ff <= pwdata[21:0];
            gdda_pkg::REG_DIR_X:    dir_x_ff    <= pwdata[17:0];
            gdda_pkg::REG_DIR_Y:    dir_y_ff    <= pwdata[17:0];
            gdda_pkg::REG_PLANE_X:  plane_x_ff  <= pwdata[17:0];
            gdda_pkg::REG_PLANE_Y:  plane_y_ff  <= pwdata[17:0];
            gdda_pkg::REG_SCREEN_W: screen_w_ff <= pwdata[12:0];
            default: ;
         endcase
      end
   end

   // derived values
   assign w_eff   = (screen_w_ff == 13'd0) ? 13'd1 : screen_w_ff;
   assign ax      = rdx_ff[gdda_pkg::RW-1] ? (gdda_pkg::RW-1)'(-rdx_ff)
                                           : (gdda_pkg::RW-1)'(rdx_ff);
   assign ay      = rdy_ff[gdda_pkg::RW-1] ? (gdda_pkg::RW-1)'(-rdy_ff)
                                           : (gdda_pkg::RW-1)'(rdy_ff);
   assign cam_mag = cam_ff[31] ? 32'(-cam_ff) : 32'(cam_ff);
   assign prod_neg = cam_ff[31] ^ ((state_ff == gdda_pkg::ST_MX) ? plane_x_ff[17]
                                                                 : plane_y_ff[17]);
   assign prod_s  = prod_neg ? -signed'(alu_rsp.result) : signed'(alu_rsp.result);
   assign prod_sh = prod_s >>> 16;
   assign partx   = rdx_ff[gdda_pkg::RW-1] ? {1'b0, player_x_ff[15:0]}
                                           : gdda_pkg::ONE_Q16 - {1'b0, player_x_ff[15:0]};
   assign party   = rdy_ff[gdda_pkg::RW-1] ? {1'b0, player_y_ff[15:0]}
                                           : gdda_pkg::ONE_Q16 - {1'b0, player_y_ff[15:0]};
   assign take_x  = sdx_ff < sdy_ff;
   assign nx      = rdx_ff[gdda_pkg::RW-1] ? mx_ff - 2'sd1 : mx_ff + 2'sd1;
   assign ny      = rdy_ff[gdda_pkg::RW-1] ? my_ff - 2'sd1 : my_ff + 2'sd1;

   // grid line crossed at the hit, distance numerator
   always_comb begin
      if (face_ff == gdda_pkg::FACE_XF || face_ff == gdda_pkg::FACE_XB) begin
         line_c   = rdx_ff[gdda_pkg::RW-1] ? mx_ff + 2'sd1 : mx_ff;
         line_d   = gdda_pkg::LW'(signed'({1'b0, player_x_ff}));
         dist_den = 64'(ax);
      end else begin
         line_c   = rdy_ff[gdda_pkg::RW-1] ? my_ff + 2'sd1 : my_ff;
         line_d   = gdda_pkg::LW'(signed'({1'b0, player_y_ff}));
         dist_den = 64'(ay);
      end
      line_q = (gdda_pkg::LW'(line_c) <<< 16) - line_d;
      line_m = line_q[gdda_pkg::LW-1] ? gdda_pkg::LW'(-line_q) : gdda_pkg::LW'(line_q);
   end

   always_comb begin
      esc_rsp.hit_face      = gdda_pkg::FACE_XF;
      esc_rsp.wall_distance = gdda_pkg::DIST_MAX;
      esc_rsp.hit_x         = '0;
      esc_rsp.hit_y         = '0;
      esc_rsp.escaped       = 1'b1;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cam_in       = cam_ff;
      rdx_in       = rdx_ff;
      rdy_in       = rdy_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      ddx_in       = ddx_ff;
      ddy_in       = ddy_ff;
      sdx_in       = sdx_ff;
      sdy_in       = sdy_ff;
      face_in      = face_ff;
      guard_in     = guard_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      alu_req      = '0;
      wr_en        = 1'b0;
      wr_bit       = 1'b0;
      wr_addr      = clr_ff;
      req_ready    = 1'b0;
      case (state_ff)
         gdda_pkg::ST_CLR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == gdda_pkg::MAP_AW'(gdda_pkg::MAP_N - 1)) begin
               state_in = gdda_pkg::ST_IDLE;
            end
         end
         gdda_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_data.command == gdda_pkg::CMD_WRITE) begin
                  wr_en   = (32'(req_data.cell_x) < gdda_pkg::MAP_W) &&
                            (32'(req_data.cell_y) < gdda_pkg::MAP_H);
                  wr_bit  = req_data.cell_is_wall;
                  wr_addr = gdda_pkg::map_addr(gdda_pkg::CW'(req_data.cell_x),
                                               gdda_pkg::CW'(req_data.cell_y));
               end else begin
                  alu_req.start = 1'b1;
                  alu_req.op    = gdda_pkg::ALU_DIV;
                  alu_req.a     = {35'd0, req_data.column, 17'd0};
                  alu_req.b     = 64'(w_eff);
                  state_in      = gdda_pkg::ST_CAM;
               end
            end
         end
         gdda_pkg::ST_CAM: begin
            if (alu_rsp.done) begin
               cam_in        = signed'(alu_rsp.result[31:0]) - 32'sd65536;
               alu_req.start = 1'b1;
               alu_req.op    = gdda_pkg::ALU_MUL;
               alu_req.a     = 64'(plane_x_ff[17] ? unsigned'(-plane_x_ff)
                                                  : unsigned'(plane_x_ff));
               alu_req.b     = 64'(cam_in[31] ? 32'(-cam_in) : 32'(cam_in));
               state_in      = gdda_pkg::ST_MX;
            end
         end
         gdda_pkg::ST_MX: begin
            if (alu_rsp.done) begin
               rdx_in        = gdda_pkg::RW'(dir_x_ff) + prod_sh[gdda_pkg::RW-1:0];
               alu_req.start = 1'b1;
               alu_req.op    = gdda_pkg::ALU_MUL;
               alu_req.a     = 64'(plane_y_ff[17] ? unsigned'(-plane_y_ff)
                                                  : unsigned'(plane_y_ff));
               alu_req.b     = 64'(cam_mag);
               state_in      = gdda_pkg::ST_MY;
            end
         end
         gdda_pkg::ST_MY: begin
            if (alu_rsp.done) begin
               rdy_in   = gdda_pkg::RW'(dir_y_ff) + prod_sh[gdda_pkg::RW-1:0];
               mx_in    = gdda_pkg::CW'(player_x_ff[21:16]);
               my_in    = gdda_pkg::CW'(player_y_ff[21:16]);
               state_in = gdda_pkg::ST_CK0;
            end
         end
         gdda_pkg::ST_CK0: begin
            if (gdda_pkg::coord_out(mx_ff, gdda_pkg::MAP_W) ||
                gdda_pkg::coord_out(my_ff, gdda_pkg::MAP_H)) begin
               pend_in  = esc_rsp;
               state_in = gdda_pkg::ST_FIN;
            end else if (rd_ff) begin
               pend_in.hit_face      = gdda_pkg::FACE_XF;
               pend_in.wall_distance = '0;
               pend_in.hit_x         = mx_ff[5:0];
               pend_in.hit_y         = my_ff[5:0];
               pend_in.escaped       = 1'b0;
               state_in              = gdda_pkg::ST_FIN;
            end else begin
               alu_req.start = 1'b1;
               alu_req.op    = gdda_pkg::ALU_DIV;
               alu_req.a     = gdda_pkg::TWO_32;
               alu_req.b     = 64'(ax);
               state_in      = gdda_pkg::ST_DX;
            end
         end
         gdda_pkg::ST_DX: begin
            if (alu_rsp.done) begin
               ddx_in        = (ax != '0) ? alu_rsp.result : gdda_pkg::DD_INF;
               alu_req.start = 1'b1;
               alu_req.op    = gdda_pkg::ALU_DIV;
               alu_req.a     = gdda_pkg::TWO_32;
               alu_req.b     = 64'(ay);
               state_in      = gdda_pkg::ST_DY;
            end
         end
         gdda_pkg::ST_DY: begin
            if (alu_rsp.done) begin
               ddy_in        = (ay != '0) ? alu_rsp.result : gdda_pkg::DD_INF;
               alu_req.start = 1'b1;
               alu_req.op    = gdda_pkg::ALU_MUL;
               alu_req.a     = 64'(partx);
               alu_req.b     = ddx_ff;
               state_in      = gdda_pkg::ST_SX;
            end
         end
         gdda_pkg::ST_SX: begin
            if (alu_rsp.done) begin
               sdx_in        = (ax != '0) ? {16'd0, alu_rsp.result[63:16]} : gdda_pkg::DD_INF;
               alu_req.start = 1'b1;
               alu_req.op    = gdda_pkg::ALU_MUL;
               alu_req.a     = 64'(party);
               alu_req.b     = ddy_ff;
               state_in      = gdda_pkg::ST_SY;
            end
         end
         gdda_pkg::ST_SY: begin
            if (alu_rsp.done) begin
               sdy_in   = (ay != '0) ? {16'd0, alu_rsp.result[63:16]} : gdda_pkg::DD_INF;
               guard_in = '0;
               state_in = gdda_pkg::ST_STEP;
            end
         end
         gdda_pkg::ST_STEP: begin
            if (guard_ff > gdda_pkg::GW'(gdda_pkg::GUARD_MAX)) begin
               pend_in  = esc_rsp;
               state_in = gdda_pkg::ST_FIN;
            end else begin
               if (take_x) begin
                  if (sdx_ff != gdda_pkg::DD_INF) begin
                     sdx_in = sdx_ff + ddx_ff;
                  end
                  mx_in   = nx;
                  face_in = rdx_ff[gdda_pkg::RW-1] ? gdda_pkg::FACE_XB : gdda_pkg::FACE_XF;
               end else begin
                  if (sdy_ff != gdda_pkg::DD_INF) begin
                     sdy_in = sdy_ff + ddy_ff;
                  end
                  my_in   = ny;
                  face_in = rdy_ff[gdda_pkg::RW-1] ? gdda_pkg::FACE_YB : gdda_pkg::FACE_YF;
               end
               if (gdda_pkg::coord_out(mx_in, gdda_pkg::MAP_W) ||
                   gdda_pkg::coord_out(my_in, gdda_pkg::MAP_H)) begin
                  pend_in  = esc_rsp;
                  state_in = gdda_pkg::ST_FIN;
               end else begin
                  state_in = gdda_pkg::ST_WCK;
               end
            end
         end
         gdda_pkg::ST_WCK: begin
            if (rd_ff) begin
               pend_in.hit_face = face_ff;
               pend_in.hit_x    = mx_ff[5:0];
               pend_in.hit_y    = my_ff[5:0];
               pend_in.escaped  = 1'b0;
               if (dist_den == 64'd0) begin
                  pend_in.wall_distance = gdda_pkg::DIST_MAX;
                  state_in              = gdda_pkg::ST_FIN;
               end else begin
                  alu_req.start = 1'b1;
                  alu_req.op    = gdda_pkg::ALU_DIV;
                  alu_req.a     = 64'({line_m, 16'd0});
                  alu_req.b     = dist_den;
                  state_in      = gdda_pkg::ST_DIST;
               end
            end else begin
               guard_in = guard_ff + 1'b1;
               state_in = gdda_pkg::ST_STEP;
            end
         end
         gdda_pkg::ST_DIST: begin
            if (alu_rsp.done) begin
               pend_in.wall_distance = (alu_rsp.result > 64'(gdda_pkg::DIST_MAX))
                                       ? gdda_pkg::DIST_MAX : alu_rsp.result[23:0];
               state_in = gdda_pkg::ST_FIN;
            end
         end
         gdda_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = gdda_pkg::ST_IDLE;
            end
         end
         default: state_in = gdda_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gdda_pkg::ST_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cam_ff   <= cam_in;
      rdx_ff   <= rdx_in;
      rdy_ff   <= rdy_in;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      ddx_ff   <= ddx_in;
      ddy_ff   <= ddy_in;
      sdx_ff   <= sdx_in;
      sdy_ff   <= sdy_in;
      face_ff  <= face_in;
      guard_ff <= guard_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   // wall map: one write port, read follows the next cell coordinates
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_bit;
      end
      rd_ff <= map_mem[gdda_pkg::map_addr(mx_in, my_in)];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_cast_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.command == gdda_pkg::CMD_CAST) |=> !req_ready)
      else $error("input taken during a cast");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == gdda_pkg::ST_FIN))
      else $error("result raised outside the finish state");

   a_escape_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.escaped) |->
         (rsp_ff.wall_distance == gdda_pkg::DIST_MAX && rsp_ff.hit_face == gdda_pkg::FACE_XF))
      else $error("escaped ray without saturated distance");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gdda_pkg::ST_CLR) |-> (!req_ready && !rsp_valid_ff))
      else $error("activity during map clear");

endmodule

// ----- tb/sv/tb_grid_ray_cast_dda_top.sv -----
// ---------------------------------------------------------------------------
// tb_grid_ray_cast_dda_top
// self-checking bench for the grid ray caster: map writes and column casts
// are driven mostly under random valid/ready gaps, each cast beat is
// compared field by field against a directed beat or an in-bench fixed
// point dda predictor; camera registers are rewritten while the block is idle
// ---------------------------------------------------------------------------
module tb_grid_ray_cast_dda_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  LAT_IDLE  = 2000;
   localparam int  RAND_ITEMS = 1820;
   localparam longint INF_DD = 64'sh4000_0000_0000_0000;

   typedef struct packed {
      logic              has_rsp;
      gdda_pkg::req_type req;
      gdda_pkg::rsp_type rsp;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   gdda_pkg::req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   gdda_pkg::rsp_type rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   bit          walls [gdda_pkg::MAP_N];
   logic [21:0] pos_x, pos_y;
   logic signed [17:0] dir_x, dir_y, pln_x, pln_y;
   logic [12:0] scr_w;

   gdda_pkg::rsp_type hit_queue [$];
   int          errors = 0;
   longint      cycles = 0;
   bit          hold_off = 0;

   grid_ray_cast_dda_top u_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 64'd20_000_000) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
   endtask

   function automatic longint fl16(longint p);
      if (p >= 0) return p / 65536;
      return -((-p + 65535) / 65536);
   endfunction

   function automatic longint absl(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic gdda_pkg::rsp_type make_rsp(logic [1:0] f, longint d, longint hx,
                                                  longint hy, logic e);
      gdda_pkg::rsp_type r;
      r.hit_face = f;
      r.wall_distance = (d > 16777215) ? gdda_pkg::DIST_MAX : d[23:0];
      r.hit_x = hx[5:0];
      r.hit_y = hy[5:0];
      r.escaped = e;
      return r;
   endfunction

   // returns 1 with the predicted beat when the item is a cast
   function automatic bit cast_ray(gdda_pkg::req_type q, output gdda_pkg::rsp_type r);
      longint w, cam, rdx, rdy, px, py, mx, my, ax, ay, ddx, ddy, fx, fy;
      longint sdx, sdy, stx, sty, ln, num, den;
      logic [1:0] face;
      if (q.command == gdda_pkg::CMD_WRITE) begin
         walls[q.cell_y * gdda_pkg::MAP_W + q.cell_x] = q.cell_is_wall;
         return 0;
      end
      w = scr_w == 0 ? 1 : scr_w;
      cam = (2 * longint'(q.column) * 65536) / w - 65536;
      rdx = longint'(dir_x) + fl16(longint'(pln_x) * cam);
      rdy = longint'(dir_y) + fl16(longint'(pln_y) * cam);
      px = pos_x; py = pos_y;
      mx = px / 65536; my = py / 65536;
      if (mx >= gdda_pkg::MAP_W || my >= gdda_pkg::MAP_H) begin
         r = make_rsp(gdda_pkg::FACE_XF, 16777215, 0, 0, 1);
         return 1;
      end
      if (walls[my * gdda_pkg::MAP_W + mx]) begin
         r = make_rsp(gdda_pkg::FACE_XF, 0, mx, my, 0);
         return 1;
      end
      ax = absl(rdx); ay = absl(rdy);
      ddx = ax != 0 ? (64'sd1 << 32) / ax : INF_DD;
      ddy = ay != 0 ? (64'sd1 << 32) / ay : INF_DD;
      fx = px & 65535; fy = py & 65535;
      sdx = ax != 0 ? (((rdx < 0) ? fx : 65536 - fx) * ddx) >>> 16 : INF_DD;
      sdy = ay != 0 ? (((rdy < 0) ? fy : 65536 - fy) * ddy) >>> 16 : INF_DD;
      stx = rdx < 0 ? -1 : 1;
      sty = rdy < 0 ? -1 : 1;
      face = gdda_pkg::FACE_XF;
      for (int g = 0; g <= gdda_pkg::GUARD_MAX; g++) begin
         if (sdx < sdy) begin
            if (sdx != INF_DD) sdx += ddx;
            mx += stx;
            face = rdx < 0 ? gdda_pkg::FACE_XB : gdda_pkg::FACE_XF;
         end else begin
            if (sdy != INF_DD) sdy += ddy;
            my += sty;
            face = rdy < 0 ? gdda_pkg::FACE_YB : gdda_pkg::FACE_YF;
         end
         if (mx < 0 || mx >= gdda_pkg::MAP_W || my < 0 || my >= gdda_pkg::MAP_H) break;
         if (walls[my * gdda_pkg::MAP_W + mx]) begin
            if (face == gdda_pkg::FACE_XF || face == gdda_pkg::FACE_XB) begin
               ln = (mx + (stx < 0 ? 1 : 0)) * 65536;
               num = absl(ln - px); den = ax;
            end else begin
               ln = (my + (sty < 0 ? 1 : 0)) * 65536;
               num = absl(ln - py); den = ay;
            end
            r = make_rsp(face, den != 0 ? (num <<< 16) / den : 16777215, mx, my, 0);
            return 1;
         end
      end
      r = make_rsp(gdda_pkg::FACE_XF, 16777215, 0, 0, 1);
      return 1;
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         gdda_pkg::REG_PLAYER_X: pos_x = val[21:0];
         gdda_pkg::REG_PLAYER_Y: pos_y = val[21:0];
         gdda_pkg::REG_DIR_X:    dir_x = val[17:0];
         gdda_pkg::REG_DIR_Y:    dir_y = val[17:0];
         gdda_pkg::REG_PLANE_X:  pln_x = val[17:0];
         gdda_pkg::REG_PLANE_Y:  pln_y = val[17:0];
         gdda_pkg::REG_SCREEN_W: scr_w = val[12:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_view(int px, int py, int dx, int dy, int lx, int ly, int sw);
      csr_write(gdda_pkg::REG_PLAYER_X, px);
      csr_write(gdda_pkg::REG_PLAYER_Y, py);
      csr_write(gdda_pkg::REG_DIR_X, dx);
      csr_write(gdda_pkg::REG_DIR_Y, dy);
      csr_write(gdda_pkg::REG_PLANE_X, lx);
      csr_write(gdda_pkg::REG_PLANE_Y, ly);
      csr_write(gdda_pkg::REG_SCREEN_W, sw);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (hit_queue.size() != 0) @(posedge clock);
      repeat (LAT_IDLE) @(posedge clock);
   endtask

   // valid stays high between back-to-back beats and drops only for a gap
   task automatic send(gdda_pkg::req_type q, bit typed, bit has, gdda_pkg::rsp_type want,
                       bit gaps);
      gdda_pkg::rsp_type r;
      int gap;
      if (gaps) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock iff req_ready);
      if (cast_ray(q, r)) hit_queue.push_back(typed ? want : r);
   endtask

   function automatic gdda_pkg::req_type wr(int x, int y, bit wl);
      gdda_pkg::req_type q;
      q = '0;
      q.command = gdda_pkg::CMD_WRITE; q.cell_x = 6'(x); q.cell_y = 6'(y);
      q.cell_is_wall = wl;
      q.column = 12'($urandom());
      return q;
   endfunction

   function automatic gdda_pkg::req_type cs(int c);
      gdda_pkg::req_type q;
      q = '0;
      q.command = gdda_pkg::CMD_CAST; q.column = 12'(c);
      q.cell_x = 6'($urandom()); q.cell_y = 6'($urandom()); q.cell_is_wall = 1'($urandom());
      return q;
   endfunction

   function automatic gdda_pkg::req_type rand_item(int wall_pct);
      if ($urandom_range(0, 99) < 40)
         return wr($urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 99) < wall_pct);
      return cs($urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 700));
   endfunction

   task automatic random_phase(int n, int wall_pct, bit border);
      for (int i = 0; i < n; i++) begin
         if (border && $urandom_range(0, 5) == 0) begin
            int k;
            k = $urandom_range(0, 63);
            case ($urandom_range(0, 3))
               0: send(wr(k, 0, 1), 0, 0, '0, 1);
               1: send(wr(k, 63, 1), 0, 0, '0, 1);
               2: send(wr(0, k, 1), 0, 0, '0, 1);
               default: send(wr(63, k, 1), 0, 0, '0, 1);
            endcase
         end else begin
            send(rand_item(wall_pct), 0, 0, '0, 1);
         end
      end
   endtask

   // receiver
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400) : $urandom_range(1, 3);
            repeat (gap - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (hit_queue.size() == 0) begin
            report("unexpected beat", 0, 0);
         end else begin
            gdda_pkg::rsp_type e;
            e = hit_queue.pop_front();
            if (rsp_data.hit_face !== e.hit_face)
               report("hit_face", rsp_data.hit_face, e.hit_face);
            if (rsp_data.wall_distance !== e.wall_distance)
               report("wall_distance", rsp_data.wall_distance, e.wall_distance);
            if (rsp_data.hit_x !== e.hit_x) report("hit_x", rsp_data.hit_x, e.hit_x);
            if (rsp_data.hit_y !== e.hit_y) report("hit_y", rsp_data.hit_y, e.hit_y);
            if (rsp_data.escaped !== e.escaped)
               report("escaped", rsp_data.escaped, e.escaped);
         end
      end
   end

   initial begin
      dir_row_type dir_rows [$];
      for (int i = 0; i < gdda_pkg::MAP_N; i++) walls[i] = 0;
      pos_x = '0; pos_y = '0; dir_x = 18'sd65536; dir_y = '0; pln_x = '0;
      pln_y = 18'sd43254;
      scr_w = 13'd640;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset: viewer at cell 0,0 of an empty map escapes
      dir_rows.push_back('{1'b1, cs(0), make_rsp(gdda_pkg::FACE_XF, 16777215, 0, 0, 1)});
      dir_rows.push_back('{1'b1, cs(4095), make_rsp(gdda_pkg::FACE_XF, 16777215, 0, 0, 1)});
      dir_rows.push_back('{1'b0, wr(0, 0, 1), '0});
      // start inside a wall
      dir_rows.push_back('{1'b1, cs(320), make_rsp(gdda_pkg::FACE_XF, 0, 0, 0, 0)});
      dir_rows.push_back('{1'b0, wr(0, 0, 0), '0});
      dir_rows.push_back('{1'b0, wr(5, 0, 1), '0});
      dir_rows.push_back('{1'b0, wr(63, 63, 1), '0});
      dir_rows.push_back('{1'b0, wr(63, 0, 1), '0});
      dir_rows.push_back('{1'b0, wr(0, 63, 1), '0});
      foreach (dir_rows[i])
         send(dir_rows[i].req, dir_rows[i].has_rsp, dir_rows[i].has_rsp,
              dir_rows[i].rsp, 0);
      for (int c = 0; c < 640; c += 71) send(cs(c), 0, 0, '0, 0);
      drain();

      // extremes of the camera registers, viewer mid map and at the largest x
      set_view(32 * 65536 + 32768, 32 * 65536 + 1, -131072, 131071, 131071, -131072, 0);
      send(cs(0), 0, 0, '0, 0);
      send(cs(4095), 0, 0, '0, 0);
      drain();
      // zero ray: both components zero walks +y
      set_view(10 * 65536, 10 * 65536, 0, 0, 0, 0, 4096);
      send(cs(100), 0, 0, '0, 0);
      drain();
      set_view(4194303, 5 * 65536, 65536, 0, 0, 43254, 1);
      send(cs(0), 0, 0, '0, 0);
      drain();

      // box the map and cast from inside with walls in the way
      set_view(20 * 65536 + 12345, 30 * 65536 + 54321, 65536, 0, 0, 43254, 640);
      for (int k = 0; k < 64; k++) begin
         send(wr(k, 0, 1), 0, 0, '0, 1);
         send(wr(k, 63, 1), 0, 0, '0, 1);
         send(wr(0, k, 1), 0, 0, '0, 1);
         send(wr(63, k, 1), 0, 0, '0, 1);
      end
      random_phase(300, 15, 1);

      // long receiver hold-off while the sender keeps offering
      hold_off = 1;
      fork
         begin
            repeat (3000) @(posedge clock);
            hold_off = 0;
         end
         random_phase(20, 10, 0);
      join
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         set_view($urandom_range(65536, 63 * 65536 - 1), $urandom_range(65536, 63 * 65536 - 1),
                  $urandom_range(0, 262143) - 131072, $urandom_range(0, 262143) - 131072,
                  $urandom_range(0, 262143) - 131072, $urandom_range(0, 262143) - 131072,
                  ph == 5 ? 4096 : $urandom_range(0, 1200));
         random_phase((RAND_ITEMS - 590) / 6, ph * 4 + 3, 1);
         drain();
      end
      for (int i = 0; i < 20; i++)
         csr_write(3'(i % 7), $urandom());
      random_phase(20, 10, 0);
      drain();

      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/gdda_pkg.sv
design/gdda_alu.sv
design/grid_ray_cast_dda_top.sv
tb/sv/tb_grid_ray_cast_dda_top.sv
